// ===== sv/oled_page_refresh_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// oled page refresh sequencer assertion macros
// concurrent checks in simulation, nothing in synthesis
// ----------------------------------------------------------------------------
`ifndef OLED_PAGE_REFRESH_SEQUENCER_CORE_MACROS_SVH
`define OLED_PAGE_REFRESH_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define OPRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("oprs assertion failed");
// expression must never be true outside reset
`define OPRS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("oprs forbidden condition seen");
`else
`define OPRS_ASSERT(lbl, clk, rstn, prop)
`define OPRS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== sv/oprs_pkg.sv =====
// ----------------------------------------------------------------------------
// oprs_pkg
// shared types, constants and the init command table of the refresh sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package oprs_pkg;

  // frame buffer geometry
  localparam int unsigned FbDepth = 1024;
  localparam int unsigned FbAw    = 10;

  // default configuration
  localparam int unsigned PagesDef      = 8;
  localparam int unsigned ColumnsDef    = 128;
  localparam int unsigned InitLengthDef = 26;

  // stream widths
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned OutTuserW = 3;

  // display command bytes
  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam logic [7:0] CmdNop      = 8'hE3;
  localparam logic [7:0] DevAddrRst  = 8'h78;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_CLOSE = 2'd2
  } req_e;

  // init command list, no-op past the listed bytes
  function automatic logic [7:0] init_byte(input logic [7:0] k);
    logic [7:0] b;
    case (k)
      8'd0:    b = 8'hAE;
      8'd1:    b = 8'h00;
      8'd2:    b = 8'h10;
      8'd3:    b = 8'h40;
      8'd4:    b = 8'hB0;
      8'd5:    b = 8'h81;
      8'd6:    b = 8'hFF;
      8'd7:    b = 8'hA1;
      8'd8:    b = 8'hA6;
      8'd9:    b = 8'h3F;
      8'd10:   b = 8'hC8;
      8'd11:   b = 8'hD3;
      8'd12:   b = 8'h00;
      8'd13:   b = 8'hD5;
      8'd14:   b = 8'h80;
      8'd15:   b = 8'hD8;
      8'd16:   b = 8'h05;
      8'd17:   b = 8'hD9;
      8'd18:   b = 8'hF1;
      8'd19:   b = 8'hDA;
      8'd20:   b = 8'h12;
      8'd21:   b = 8'hDB;
      8'd22:   b = 8'h30;
      8'd23:   b = 8'h8D;
      8'd24:   b = 8'h14;
      8'd25:   b = 8'hAF;
      default: b = CmdNop;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/oprs_ram.sv =====
// ----------------------------------------------------------------------------
// oprs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module oprs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/oled_page_refresh_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// oled_page_refresh_sequencer_core
// page refresh sequencer for an i2c monochrome display with frame buffer
// ----------------------------------------------------------------------------
// usage
//   s_axis: input items. tuser selects store (write fb_byte at fb_index into
//   the frame buffer, no result) or tick (advance the bus sequencer one step
//   using the bus status flags in tdata).
//   m_axis: result items, one per tick except while waiting for the end of a
//   transaction. tuser tells open / send / close and command vs data,
//   tlast marks the byte that ends a transaction.
//   cfg: one register, the i2c write address, always ready.
// timing
//   one item per cycle sustained while m_axis takes results; a result shows on
//   m_axis after its tick passes the result stage register (sequencer step and
//   frame buffer read port) and then the output register
// reset
//   after reset the 1024 entry frame buffer is zeroed by a clearing pass,
//   one entry a cycle, during which s_axis is not ready
//   (cfg writes are still taken); the first transaction sends the init list
// stalls
//   with m_axis stalled, one result waits in the output register and one in
//   the stage behind it; s_axis then drops ready until room frees up
// ----------------------------------------------------------------------------
`default_nettype none

`include "oled_page_refresh_sequencer_core_macros.svh"

module oled_page_refresh_sequencer_core #(
  parameter int unsigned PAGES       = oprs_pkg::PagesDef,
  parameter int unsigned COLUMNS     = oprs_pkg::ColumnsDef,
  parameter int unsigned INIT_LENGTH = oprs_pkg::InitLengthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input items
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // fb_index[9:0], fb_byte[17:10], bus_granted[18], bus_finished[19],
  // bus_failed[20], zero fill above
  input  wire logic [oprs_pkg::InTdataW-1:0]  s_axis_tdata,
  // operation[0]
  input  wire logic [oprs_pkg::InTuserW-1:0]  s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // byte_value[7:0], first_byte[8], frame_done[9], error_seen[10], zero fill
  output logic      [oprs_pkg::OutTdataW-1:0] m_axis_tdata,
  // request[1:0], is_data[2]
  output logic      [oprs_pkg::OutTuserW-1:0] m_axis_tuser,
  // last_byte
  output logic                                m_axis_tlast,
  // configuration write
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [7:0]                     cfg_data_i
);

  localparam int unsigned FbAw   = oprs_pkg::FbAw;
  localparam int unsigned PgW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned MaxLen = (COLUMNS > INIT_LENGTH) ? COLUMNS : INIT_LENGTH;
  localparam int unsigned CntW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  // transaction kind, one-hot
  typedef enum logic [4:0] {
    PH_INIT = 5'b00001,
    PH_POS1 = 5'b00010,
    PH_POS2 = 5'b00100,
    PH_POS3 = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  // bus step, one-hot
  typedef enum logic [3:0] {
    BS_OPEN  = 4'b0001,
    BS_SEND  = 4'b0010,
    BS_WAIT  = 4'b0100,
    BS_CLOSE = 4'b1000
  } step_e;

  typedef struct packed {
    oprs_pkg::req_e request;
    logic           is_data;
    logic [7:0]     byte_value;
    logic           first_byte;
    logic           last_byte;
    logic           frame_done;
    logic           error_seen;
  } res_t;

  // ---------------------------------------------------------------- config
  logic [7:0] i2c_addr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i2c_addr_q <= oprs_pkg::DevAddrRst;
    end else if (cfg_valid_i) begin
      i2c_addr_q <= cfg_data_i;
    end
  end

  // -------------------------------------------------------- clearing pass
  logic            clr_active_q, clr_active_d;
  logic [FbAw-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + FbAw'(1);
      if (clr_addr_q == FbAw'(oprs_pkg::FbDepth - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  // ------------------------------------------------------------ handshake
  logic a_valid_q, a_valid_d;
  logic m_valid_q;
  logic a_move;
  logic in_acc;
  logic is_tick;
  logic is_store;

  // result stage hands over when the output register is free or drains
  assign a_move        = a_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_active_q && (!a_valid_q || !m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = in_acc && (s_axis_tuser[0] == oprs_pkg::OP_TICK);
  assign is_store      = in_acc && (s_axis_tuser[0] == oprs_pkg::OP_STORE);

  // input field slices
  logic [FbAw-1:0] in_fb_index;
  logic [7:0]      in_fb_byte;
  logic            in_granted, in_finished, in_failed;

  assign in_fb_index = s_axis_tdata[9:0];
  assign in_fb_byte  = s_axis_tdata[17:10];
  assign in_granted  = s_axis_tdata[18];
  assign in_finished = s_axis_tdata[19];
  assign in_failed   = s_axis_tdata[20];

  // ------------------------------------------------------ sequencer state
  phase_e          phase_q, phase_d;
  step_e           step_q, step_d;
  logic [PgW-1:0]  page_q, page_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;

  phase_e          ph;
  logic [CntW:0]   len;
  logic            last_of_trans;
  logic [PgW-1:0]  page_inc;
  logic [FbAw-1:0] fb_raddr;
  logic            fb_re;
  res_t            res_d, a_res_q;
  logic            sel_fb_d, a_sel_fb_q;

  // effective phase: init list whenever the error flag is set
  always_comb begin
    if (err_q) begin
      ph = PH_INIT;
    end else if (phase_q == PH_INIT) begin
      ph = PH_POS1;
    end else begin
      ph = phase_q;
    end
  end

  always_comb begin
    case (ph)
      PH_INIT: len = (CntW + 1)'(INIT_LENGTH);
      PH_DATA: len = (CntW + 1)'(COLUMNS);
      default: len = (CntW + 1)'(1);
    endcase
  end

  assign last_of_trans = ({1'b0, cnt_q} + (CntW + 1)'(1)) >= len;
  assign page_inc      = (page_q == PgW'(PAGES - 1)) ? '0 : page_q + PgW'(1);
  // page * columns + column, wrapped to the buffer size
  assign fb_raddr      = FbAw'(32'(page_q) * 32'(COLUMNS) + 32'(cnt_q));

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    page_d    = page_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    res_d     = '{request: oprs_pkg::REQ_OPEN, is_data: 1'b0, byte_value: 8'h00,
                  first_byte: 1'b0, last_byte: 1'b0, frame_done: 1'b0,
                  error_seen: 1'b0};
    sel_fb_d  = 1'b0;
    fb_re     = 1'b0;
    a_valid_d = a_valid_q;

    if (a_move) begin
      a_valid_d = 1'b0;
    end

    if (is_tick) begin
      a_valid_d = 1'b1;
      case (step_q)
        BS_OPEN: begin
          res_d.request    = oprs_pkg::REQ_OPEN;
          res_d.byte_value = i2c_addr_q;
          if (in_granted) begin
            step_d = BS_SEND;
            cnt_d  = '0;
          end
        end
        BS_SEND: begin
          res_d.request    = oprs_pkg::REQ_SEND;
          res_d.is_data    = (ph == PH_DATA);
          res_d.first_byte = (cnt_q == '0);
          case (ph)
            PH_INIT: res_d.byte_value = oprs_pkg::init_byte(8'(cnt_q));
            PH_POS1: res_d.byte_value = 8'(oprs_pkg::CmdPageBase + 8'(page_q));
            PH_POS2: res_d.byte_value = oprs_pkg::CmdColLow;
            PH_POS3: res_d.byte_value = oprs_pkg::CmdColHigh;
            default: begin
              // pixel byte comes from the registered buffer read port when the result moves on
              sel_fb_d = 1'b1;
              fb_re    = 1'b1;
            end
          endcase
          if (last_of_trans) begin
            res_d.last_byte = 1'b1;
            cnt_d           = '0;
            step_d          = BS_WAIT;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        BS_WAIT: begin
          // no result while the transaction runs
          a_valid_d = 1'b0;
          if (in_finished) begin
            step_d = BS_CLOSE;
          end
        end
        default: begin
          res_d.request    = oprs_pkg::REQ_CLOSE;
          res_d.error_seen = in_failed;
          step_d           = BS_OPEN;
          cnt_d            = '0;
          err_d            = in_failed;
          case (ph)
            PH_INIT: phase_d = PH_POS1;
            PH_POS1: phase_d = PH_POS2;
            PH_POS2: phase_d = PH_POS3;
            PH_POS3: phase_d = PH_DATA;
            default: begin
              phase_d          = PH_POS1;
              page_d           = page_inc;
              res_d.frame_done = (page_inc == '0);
            end
          endcase
        end
      endcase
    end else if (is_store) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_INIT;
      step_q    <= BS_OPEN;
      page_q    <= '0;
      cnt_q     <= '0;
      err_q     <= 1'b1;
      a_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      step_q    <= step_d;
      page_q    <= page_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      a_valid_q <= a_valid_d;
    end
  end

  // result stage payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      a_res_q    <= res_d;
      a_sel_fb_q <= sel_fb_d;
    end
  end

  // ---------------------------------------------------------- frame buffer
  logic            fb_we;
  logic [FbAw-1:0] fb_waddr;
  logic [7:0]      fb_wdata;
  logic [7:0]      fb_rdata;

  assign fb_we    = clr_active_q || is_store;
  assign fb_waddr = clr_active_q ? clr_addr_q : in_fb_index;
  assign fb_wdata = clr_active_q ? 8'h00 : in_fb_byte;

  oprs_ram #(
    .Width (8),
    .Depth (oprs_pkg::FbDepth)
  ) u_fb_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .re_i    (fb_re),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // ------------------------------------------------------ output register
  res_t m_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (a_move) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      m_res_q <= a_res_q;
      if (a_sel_fb_q) begin
        m_res_q.byte_value <= fb_rdata;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_res_q.error_seen, m_res_q.frame_done,
                          m_res_q.first_byte, m_res_q.byte_value};
  assign m_axis_tuser  = {m_res_q.is_data, m_res_q.request};
  assign m_axis_tlast  = m_res_q.last_byte;

  // ------------------------------------------------------------ assertions
  // nothing moves through the pipe while the buffer is being cleared
  `OPRS_ASSERT_NEVER(a_clr_idle, clk_i, rst_ni, clr_active_q && (a_valid_q || m_valid_q))
  // a tick while waiting for the bus leaves no result behind
  `OPRS_ASSERT(a_wait_silent, clk_i, rst_ni, (is_tick && step_q == BS_WAIT) |=> !a_valid_q)
  // frame done only ever rides on a close
  `OPRS_ASSERT(a_frame_on_close, clk_i, rst_ni,
               (a_valid_q && a_res_q.frame_done) |-> (a_res_q.request == oprs_pkg::REQ_CLOSE))
  // a transaction end marker only on a sent byte
  `OPRS_ASSERT(a_last_on_send, clk_i, rst_ni,
               (m_valid_q && m_res_q.last_byte) |-> (m_res_q.request == oprs_pkg::REQ_SEND))

endmodule

`default_nettype wire
